>>> rtl/bna_pkg.sv
// Shared types and codes for the bitmap number allocator.
// No dependencies; imported by the top level and the search unit.
package bna_pkg;

   // Width of a 1-based number on the request and response ports.
   localparam int NUM_W    = 14;
   localparam int STATUS_W = 2;

   typedef logic [NUM_W-1:0]    num_type;
   typedef logic [STATUS_W-1:0] status_type;

   // Response status codes.
   localparam status_type STATUS_DONE  = 2'd0;
   localparam status_type STATUS_FULL  = 2'd1;
   localparam status_type STATUS_RANGE = 2'd2;

   // Request modes.
   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_FREE  = 1'b1;

   // Widest limit the search unit compares against, in bits.
   localparam int LIMIT_CMP_W = 32;

endpackage

>>> rtl/bitmap_number_allocator_top.sv
// Top level of the bitmap number allocator: sequencer, count register, output stage.
// Depends on bna_pkg, bna_ram and bna_ffz.

// First-fit allocator of the numbers 1 to the count register value, capped at
// MAX_ENTRIES. After reset the block clears all WORD_COUNT bitmap words
// (MAX_ENTRIES / WORD_BITS rounded up, 256 by default) and accepts no request
// meanwhile. An allocate request reads one bitmap word per cycle through the RAM
// read port and the find-first-zero unit, scanning 1 to WORD_COUNT words. A free
// request passes through a reciprocal multiply for the word address, a read, a
// read-modify-write and the response stage. A free of zero or above the count goes
// straight to the response stage with a range status. One request is in flight at
// a time and the block is ready again on the cycle after its response is loaded,
// so a new one may be accepted while the previous response waits.
module bitmap_number_allocator_top #(
   parameter int MAX_ENTRIES = 8192,
   parameter int WORD_BITS   = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  bna_pkg::num_type  csr_wr_data,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_mode,
   input  bna_pkg::num_type  req_number_to_free,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output bna_pkg::num_type  rsp_allocated_number,
   output bna_pkg::status_type rsp_status
);
   import bna_pkg::*;

   localparam int WORD_COUNT = (MAX_ENTRIES + WORD_BITS - 1) / WORD_BITS;
   localparam int ADDR_W     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
   localparam int CNT_W      = $clog2(MAX_ENTRIES + 1);
   localparam int IDX_W      = $clog2(MAX_ENTRIES);
   localparam int BIT_W      = $clog2(WORD_BITS);
   localparam int SHIFT      = IDX_W + BIT_W;
   localparam int RECIP_W    = IDX_W + 2;
   localparam int PROD_W     = ((IDX_W + RECIP_W) > (SHIFT + ADDR_W)) ?
                               (IDX_W + RECIP_W) : (SHIFT + ADDR_W);
   localparam longint RECIP_VAL = ((64'd1 << SHIFT) + WORD_BITS - 1) / WORD_BITS;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_VAL);
   localparam logic [WORD_BITS-1:0] BIT_ONE = WORD_BITS'(1);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_FREE_Q,
      ST_FREE_RD,
      ST_FREE_WR,
      ST_RESP
   } state_type;

   state_type         state_ff, state_in;
   num_type           entries_ff;
   logic [ADDR_W-1:0] word_ff, word_in;
   logic [CNT_W-1:0]  remain_ff, remain_in;
   logic [CNT_W-1:0]  base_ff, base_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [ADDR_W-1:0] quot_ff, quot_in;
   logic [BIT_W-1:0]  bit_ff, bit_in;
   num_type           res_num_ff, res_num_in;
   status_type        res_status_ff, res_status_in;
   logic              rsp_valid_ff, rsp_valid_in;
   num_type           rsp_num_ff, rsp_num_in;
   status_type        rsp_status_ff, rsp_status_in;

   logic [CNT_W-1:0]     active_count;
   logic                 req_accept;
   logic                 out_free;
   logic                 num_bad;
   logic [PROD_W-1:0]    product;
   logic                 ram_wr_en;
   logic [ADDR_W-1:0]    ram_wr_addr;
   logic [WORD_BITS-1:0] ram_wr_data;
   logic [ADDR_W-1:0]    ram_rd_addr;
   logic [WORD_BITS-1:0] ram_rd_data;
   logic                 ffz_found;
   logic [BIT_W-1:0]     ffz_bit;
   logic                 last_word;

   // Count register; a value above the capacity acts as the capacity.
   always_ff @(posedge clock) begin
      if (reset) begin
         entries_ff <= num_type'(8192);
      end else if (csr_wr_en) begin
         entries_ff <= csr_wr_data;
      end
   end

   assign active_count = (32'(entries_ff) > 32'(MAX_ENTRIES)) ?
                         CNT_W'(MAX_ENTRIES) : CNT_W'(entries_ff);

   // Handshake terms and the range check of a free request.
   assign req_ready  = (state_ff == ST_IDLE);
   assign req_accept = req_valid && req_ready;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign num_bad    = (req_number_to_free == '0) ||
                       (32'(req_number_to_free) > 32'(active_count));

   // Word address of a freed number by multiplication with a rounded-up reciprocal.
   assign product = PROD_W'(idx_ff) * PROD_W'(RECIP);

   // The current word is the last one that holds managed numbers.
   assign last_word = (32'(remain_ff) <= 32'(WORD_BITS));

   bna_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (WORD_COUNT)
   ) u_bitmap (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   bna_ffz #(
      .WORD_BITS (WORD_BITS),
      .LIMIT_W   (CNT_W)
   ) u_ffz (
      .word    (ram_rd_data),
      .limit   (remain_ff),
      .found   (ffz_found),
      .bit_idx (ffz_bit)
   );

   // Sequencer: clearing pass, word scan, free read-modify-write and response.
   always_comb begin
      state_in      = state_ff;
      word_in       = word_ff;
      remain_in     = remain_ff;
      base_in       = base_ff;
      idx_in        = idx_ff;
      quot_in       = quot_ff;
      bit_in        = bit_ff;
      res_num_in    = res_num_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_num_in    = rsp_num_ff;
      rsp_status_in = rsp_status_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = word_ff;
      ram_wr_data   = '0;
      ram_rd_addr   = '0;

      case (state_ff)
         ST_CLEAR: begin
            ram_wr_en = 1'b1;
            word_in   = word_ff + ADDR_W'(1);
            if (32'(word_ff) == 32'(WORD_COUNT - 1)) begin
               word_in  = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            ram_rd_addr = '0;
            if (req_accept) begin
               res_num_in = '0;
               if (req_mode == MODE_ALLOC) begin
                  word_in   = '0;
                  remain_in = active_count;
                  base_in   = '0;
                  state_in  = ST_SCAN;
               end else if (num_bad) begin
                  res_status_in = STATUS_RANGE;
                  state_in      = ST_RESP;
               end else begin
                  idx_in   = IDX_W'(32'(req_number_to_free) - 32'd1);
                  state_in = ST_FREE_Q;
               end
            end
         end
         ST_SCAN: begin
            // Next word is read while the current one is searched.
            ram_rd_addr = word_ff + ADDR_W'(1);
            if (ffz_found) begin
               ram_wr_en     = 1'b1;
               ram_wr_data   = ram_rd_data | (BIT_ONE << ffz_bit);
               res_num_in    = num_type'(32'(base_ff) + 32'(ffz_bit) + 32'd1);
               res_status_in = STATUS_DONE;
               state_in      = ST_RESP;
            end else if (last_word) begin
               res_num_in    = '0;
               res_status_in = STATUS_FULL;
               state_in      = ST_RESP;
            end else begin
               word_in   = word_ff + ADDR_W'(1);
               remain_in = remain_ff - CNT_W'(WORD_BITS);
               base_in   = base_ff + CNT_W'(WORD_BITS);
            end
         end
         ST_FREE_Q: begin
            quot_in  = product[SHIFT +: ADDR_W];
            state_in = ST_FREE_RD;
         end
         ST_FREE_RD: begin
            ram_rd_addr = quot_ff;
            bit_in      = BIT_W'(32'(idx_ff) - 32'(quot_ff) * 32'(WORD_BITS));
            state_in    = ST_FREE_WR;
         end
         ST_FREE_WR: begin
            ram_rd_addr   = quot_ff;
            ram_wr_en     = 1'b1;
            ram_wr_addr   = quot_ff;
            ram_wr_data   = ram_rd_data & ~(BIT_ONE << bit_ff);
            res_status_in = STATUS_DONE;
            state_in      = ST_RESP;
         end
         ST_RESP: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_num_in    = res_num_ff;
               rsp_status_in = res_status_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         word_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         word_ff      <= word_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      remain_ff     <= remain_in;
      base_ff       <= base_in;
      idx_ff        <= idx_in;
      quot_ff       <= quot_in;
      bit_ff        <= bit_in;
      res_num_ff    <= res_num_in;
      res_status_ff <= res_status_in;
      rsp_num_ff    <= rsp_num_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_allocated_number = rsp_num_ff;
   assign rsp_status           = rsp_status_ff;

   // A non-zero number is only ever returned with a successful status.
   a_num_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_num_ff != '0)) |-> (rsp_status_ff == STATUS_DONE))
      else $error("non-zero number returned without done status");

   // The scan position plus the remaining count stays fixed while scanning.
   a_scan_sum: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SCAN) && $past(state_ff == ST_SCAN)) |->
      ((32'(base_ff) + 32'(remain_ff)) == ($past(32'(base_ff)) + $past(32'(remain_ff)))))
      else $error("scan base and remaining count drifted");

   // The bitmap is written only while clearing, on a hit, or when freeing.
   a_wr_state: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> ((state_ff == ST_CLEAR) || (state_ff == ST_SCAN) ||
                     (state_ff == ST_FREE_WR)))
      else $error("bitmap written outside a writing state");

   // A loaded response is presented on the cycle after the response state.
   a_resp_load: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_RESP) && out_free) |=> (rsp_valid_ff && (state_ff == ST_IDLE)))
      else $error("response not presented after completion");

endmodule

>>> rtl/bna_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module bna_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/bna_ffz.sv
// Find-first-zero unit: lowest clear bit of one bitmap word below a limit.
// Depends on bna_pkg for the width of the limit comparison.
module bna_ffz #(
   parameter int WORD_BITS = 32,
   parameter int LIMIT_W   = 14
) (
   input  logic [WORD_BITS-1:0]         word,
   input  logic [LIMIT_W-1:0]           limit,
   output logic                         found,
   output logic [$clog2(WORD_BITS)-1:0] bit_idx
);
   import bna_pkg::*;

   logic [LIMIT_CMP_W-1:0] limit_wide;

   assign limit_wide = LIMIT_CMP_W'(limit);

   // Scan from the top bit down so that the lowest eligible clear bit wins.
   always_comb begin
      found   = 1'b0;
      bit_idx = '0;
      for (int b = WORD_BITS - 1; b >= 0; b--) begin
         if (!word[b] && (LIMIT_CMP_W'(b) < limit_wide)) begin
            found   = 1'b1;
            bit_idx = ($clog2(WORD_BITS))'(b);
         end
      end
   end

endmodule
